@@ rtl/rsbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsbm_pkg
// Shared types and constants for the rotated sprite blit mapper.
// ----------------------------------------------------------------------------
package rsbm_pkg;

  // Default side of the square texel store
  localparam int unsigned STORE_DIM_DEF = 256;
  // Box coordinates wrap at this size; must stay a power of two
  localparam int unsigned BOX_DIM       = 2048;

  localparam logic [31:0] ROUND_BIAS = 32'h0000_8000;

  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIN_Q16     = 3'd0,
    CFG_COS_Q16     = 3'd1,
    CFG_HALF_BOX_W  = 3'd2,
    CFG_HALF_BOX_H  = 3'd3,
    CFG_RECT_LEFT   = 3'd4,
    CFG_RECT_TOP    = 3'd5,
    CFG_RECT_WIDTH  = 3'd6,
    CFG_RECT_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  load_col;
    logic [7:0]  load_row;
    logic [7:0]  load_value;
    logic [10:0] box_x;
    logic [10:0] box_y;
  } in_word_t;

  typedef struct packed {
    logic       write_dest;
    logic [7:0] texel_out;
    logic       inside_source;
  } out_word_t;

  typedef struct packed {
    logic signed [17:0] sin_q16;
    logic signed [17:0] cos_q16;
    logic [9:0]         half_box_width;
    logic [9:0]         half_box_height;
    logic [7:0]         rect_left;
    logic [7:0]         rect_top;
    logic [8:0]         rect_width;
    logic [8:0]         rect_height;
  } cfg_t;

  // Load enables of the pipeline registers past the input stage
  typedef struct packed {
    logic b;
    logic c;
    logic d;
    logic e;
  } stage_en_t;

  // Fields that ride along with an item untouched by the arithmetic
  typedef struct packed {
    logic       is_map;
    logic [7:0] load_col;
    logic [7:0] load_row;
    logic [7:0] load_value;
  } meta_t;

  // Hand-over from the mapping arithmetic to the texel store
  typedef struct packed {
    meta_t      meta;
    logic       rect_in;
    logic [9:0] src_col;
    logic [9:0] src_row;
  } lookup_t;

endpackage

@@ rtl/rotated_sprite_blit_mapper.sv @@
// ----------------------------------------------------------------------------
// rotated_sprite_blit_mapper
// Q16 affine mapper from rotated bounding box pixels to a source texel store.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o    | rsbm_pkg::in_word_t
//  out     | source    | out_valid_o / out_stall_i  | rsbm_pkg::out_word_t
//  cfg     | sink      | cfg_we_i (no back-pressure)| cfg_idx_i, cfg_data_i
//
//  One word per clock in and out while the output is not stalled; the result
//  passes through the five-register pipeline (stages A..E).
//  Each stage moves when it is empty or the stage after it moves, so bubbles
//  close up under an output stall and the input keeps taking words.
//  in_stall_o rises only when every stage is full and the output is stalled.
//  Reset clears the valid bits and loads the configuration reset values; the
//  texel memory is not cleared and needs no sweep after reset.
// ----------------------------------------------------------------------------
module rotated_sprite_blit_mapper #(
  parameter int unsigned STORE_DIM = rsbm_pkg::STORE_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rsbm_pkg::in_word_t                  in_data_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rsbm_pkg::out_word_t                 out_data_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rsbm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsbm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  rsbm_pkg::cfg_t      cfg_q;
  rsbm_pkg::in_word_t  word_a_q;
  rsbm_pkg::stage_en_t en;
  rsbm_pkg::lookup_t   lkp;

  // valid bits of stages A..E
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  // --- configuration registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sin_q16:         18'sd0,
                 cos_q16:         18'sh10000,
                 half_box_width:  10'd0,
                 half_box_height: 10'd0,
                 rect_left:       8'd0,
                 rect_top:        8'd0,
                 rect_width:      9'd0,
                 rect_height:     9'd0};
    end else if (cfg_we_i) begin
      unique case (rsbm_pkg::cfg_idx_e'(cfg_idx_i))
        rsbm_pkg::CFG_SIN_Q16:     cfg_q.sin_q16         <= $signed(cfg_data_i);
        rsbm_pkg::CFG_COS_Q16:     cfg_q.cos_q16         <= $signed(cfg_data_i);
        rsbm_pkg::CFG_HALF_BOX_W:  cfg_q.half_box_width  <= cfg_data_i[9:0];
        rsbm_pkg::CFG_HALF_BOX_H:  cfg_q.half_box_height <= cfg_data_i[9:0];
        rsbm_pkg::CFG_RECT_LEFT:   cfg_q.rect_left       <= cfg_data_i[7:0];
        rsbm_pkg::CFG_RECT_TOP:    cfg_q.rect_top        <= cfg_data_i[7:0];
        rsbm_pkg::CFG_RECT_WIDTH:  cfg_q.rect_width      <= cfg_data_i[8:0];
        rsbm_pkg::CFG_RECT_HEIGHT: cfg_q.rect_height     <= cfg_data_i[8:0];
      endcase
    end
  end

  // --- pipeline flow: a stage loads when empty or when it hands on ---
  always_comb begin
    rdy_e = !v_e_q || !out_stall_i;
    rdy_d = !v_d_q || rdy_e;
    rdy_c = !v_c_q || rdy_d;
    rdy_b = !v_b_q || rdy_c;
    rdy_a = !v_a_q || rdy_b;
    en.b  = rdy_b;
    en.c  = rdy_c;
    en.d  = rdy_d;
    en.e  = rdy_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= in_valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_e) v_e_q <= v_d_q;
    end
  end

  // stage A: input register
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      word_a_q <= in_data_i;
    end
  end

  // stages B..D: products, partial sums, final sums and rectangle test
  rsbm_map_arith u_arith (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .word_i (word_a_q),
    .lkp_o  (lkp)
  );

  // stage E: texel memory write or read; D's valid bit guards the write
  rsbm_texel_store #(
    .STORE_DIM (STORE_DIM)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (en),
    .valid_i (v_d_q),
    .lkp_i   (lkp),
    .word_o  (out_data_o)
  );

  assign in_stall_o  = !rdy_a;
  assign out_valid_o = v_e_q;

endmodule

@@ rtl/rsbm_map_arith.sv @@
// ----------------------------------------------------------------------------
// rsbm_map_arith
// Three register stages: affine products, partial sums, final sums and
// source rectangle test.
// ----------------------------------------------------------------------------
module rsbm_map_arith (
  input  logic                clk_i,
  input  rsbm_pkg::stage_en_t en_i,
  input  rsbm_pkg::cfg_t      cfg_i,
  input  rsbm_pkg::in_word_t  word_i,
  output rsbm_pkg::lookup_t   lkp_o
);

  // Stage B inputs
  logic [10:0]        x_w;
  logic [10:0]        y_w;
  logic signed [11:0] dy;
  logic signed [11:0] xs;
  logic signed [10:0] cxs;
  logic signed [17:0] sin_s;
  logic signed [17:0] cos_s;
  rsbm_pkg::meta_t    meta_in;

  // Stage B registers
  logic signed [28:0] p_cc_q, p_sc_q;
  logic signed [29:0] p_sd_q, p_cd_q, p_xc_q, p_xs_q;
  logic signed [28:0] p_cc_d, p_sc_d;
  logic signed [29:0] p_sd_d, p_cd_d, p_xc_d, p_xs_d;
  rsbm_pkg::meta_t    meta_b_q;

  // Stage C registers
  logic [31:0]     ux_d, vx_d, uy_d, vy_d;
  logic [31:0]     ux_q, vx_q, uy_q, vy_q;
  logic [31:0]     xd, yd;
  rsbm_pkg::meta_t meta_c_q;

  // Stage D
  logic [31:0]       sx, sy;
  rsbm_pkg::lookup_t lkp_d, lkp_q;

  // --- products ---
  always_comb begin
    x_w     = 11'(32'(word_i.box_x) % rsbm_pkg::BOX_DIM);
    y_w     = 11'(32'(word_i.box_y) % rsbm_pkg::BOX_DIM);
    dy      = $signed({2'b00, cfg_i.half_box_height}) - $signed({1'b0, y_w});
    xs      = $signed({1'b0, x_w});
    cxs     = $signed({1'b0, cfg_i.half_box_width});
    sin_s   = $signed(cfg_i.sin_q16);
    cos_s   = $signed(cfg_i.cos_q16);
    p_cc_d  = cos_s * cxs;
    p_sc_d  = sin_s * cxs;
    p_sd_d  = sin_s * dy;
    p_cd_d  = cos_s * dy;
    p_xc_d  = xs * cos_s;
    p_xs_d  = xs * sin_s;
    meta_in = '{is_map:     (word_i.req_type == rsbm_pkg::REQ_MAP),
                load_col:   word_i.load_col,
                load_row:   word_i.load_row,
                load_value: word_i.load_value};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      p_cc_q   <= p_cc_d;
      p_sc_q   <= p_sc_d;
      p_sd_q   <= p_sd_d;
      p_cd_q   <= p_cd_d;
      p_xc_q   <= p_xc_d;
      p_xs_q   <= p_xs_d;
      meta_b_q <= meta_in;
    end
  end

  // --- partial sums, all mod 2^32 ---
  always_comb begin
    xd   = ({23'd0, cfg_i.rect_width}  - {21'd0, cfg_i.half_box_width,  1'b0}) << 15;
    yd   = ({23'd0, cfg_i.rect_height} - {21'd0, cfg_i.half_box_height, 1'b0}) << 15;
    ux_d = {6'd0, cfg_i.half_box_width,  16'd0} - 32'(p_cc_q) + xd + rsbm_pkg::ROUND_BIAS;
    uy_d = {6'd0, cfg_i.half_box_height, 16'd0} - 32'(p_sc_q) + yd + rsbm_pkg::ROUND_BIAS;
    vx_d = 32'(p_sd_q) + 32'(p_xc_q);
    vy_d = 32'(p_xs_q) - 32'(p_cd_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      ux_q     <= ux_d;
      vx_q     <= vx_d;
      uy_q     <= uy_d;
      vy_q     <= vy_d;
      meta_c_q <= meta_b_q;
    end
  end

  // --- final sums, floor and rectangle test ---
  // Upper halves of 0x8000 and above are negative and fail the compare.
  always_comb begin
    sx            = ux_q + vx_q;
    sy            = uy_q + vy_q;
    lkp_d.meta    = meta_c_q;
    lkp_d.rect_in = (sx[31:16] < {7'd0, cfg_i.rect_width}) &&
                    (sy[31:16] < {7'd0, cfg_i.rect_height});
    lkp_d.src_col = {1'b0, sx[24:16]} + {2'b00, cfg_i.rect_left};
    lkp_d.src_row = {1'b0, sy[24:16]} + {2'b00, cfg_i.rect_top};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.d) begin
      lkp_q <= lkp_d;
    end
  end

  assign lkp_o = lkp_q;

endmodule

@@ rtl/rsbm_texel_store.sv @@
// ----------------------------------------------------------------------------
// rsbm_texel_store
// Source texel memory: load items write, map items read, one port each,
// read data registered. Forms the result word.
// ----------------------------------------------------------------------------
module rsbm_texel_store #(
  parameter int unsigned STORE_DIM = rsbm_pkg::STORE_DIM_DEF
) (
  input  logic                clk_i,
  input  rsbm_pkg::stage_en_t en_i,
  input  logic                valid_i,
  input  rsbm_pkg::lookup_t   lkp_i,
  output rsbm_pkg::out_word_t word_o
);

  localparam int unsigned CW = $clog2(STORE_DIM);

  logic [7:0] mem_q [STORE_DIM][STORE_DIM];

  logic          wr_en;
  logic          inside_d;
  logic [CW-1:0] wr_col, wr_row, rd_col, rd_row;

  logic       inside_q;
  logic       is_map_q;
  logic [7:0] rdata_q;

  // only a real load word may touch the memory, never a bubble
  always_comb begin
    wr_en    = valid_i && !lkp_i.meta.is_map &&
               (32'(lkp_i.meta.load_col) < STORE_DIM) &&
               (32'(lkp_i.meta.load_row) < STORE_DIM);
    inside_d = lkp_i.meta.is_map && lkp_i.rect_in &&
               (32'(lkp_i.src_col) < STORE_DIM) &&
               (32'(lkp_i.src_row) < STORE_DIM);
    wr_col   = CW'(lkp_i.meta.load_col);
    wr_row   = CW'(lkp_i.meta.load_row);
    rd_col   = CW'(lkp_i.src_col);
    rd_row   = CW'(lkp_i.src_row);
  end

  // Write and read belong to different words, so order is kept by the pipe
  always_ff @(posedge clk_i) begin
    if (en_i.e) begin
      if (wr_en) begin
        mem_q[wr_row][wr_col] <= lkp_i.meta.load_value;
      end
      rdata_q  <= mem_q[rd_row][rd_col];
      inside_q <= inside_d;
      is_map_q <= lkp_i.meta.is_map;
    end
  end

  always_comb begin
    word_o.inside_source = inside_q;
    word_o.texel_out     = inside_q ? rdata_q : 8'd0;
    word_o.write_dest    = is_map_q && inside_q && (rdata_q != 8'd0);
  end

endmodule

@@ rtl/rsbm_checker.sv @@
// ----------------------------------------------------------------------------
// rsbm_checker
// Port-level checks for the rotated sprite blit mapper, bound to the top.
// ----------------------------------------------------------------------------
module rsbm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input rsbm_pkg::in_word_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input rsbm_pkg::out_word_t             out_data_o
);

  // a stalled input word stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // the input only backs up while a valid result word is stalled at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a destination write needs an inside, opaque texel
  a_write_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_dest |->
      out_data_o.inside_source && (out_data_o.texel_out != 8'd0))
    else $error("write without an inside nonzero texel");

  // outside the rectangle the texel reads as transparent
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_source |-> out_data_o.texel_out == 8'd0)
    else $error("texel nonzero outside source rectangle");

endmodule

bind rotated_sprite_blit_mapper rsbm_checker u_rsbm_checker (.*);

@@ tb/blit_checker.sv @@
// ----------------------------------------------------------------------------
// blit_checker
// Watches the word channels of the blit mapper and scores every result word.
// Keeps a shadow of the registers and of the texel store, predicts each
// result from the accepted input word and compares it with the oldest one
// still waiting. Unexpected words and field mismatches raise the fail count.
// ----------------------------------------------------------------------------
module blit_checker #(
  parameter int unsigned STORE_DIM = rsbm_pkg::STORE_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rsbm_pkg::in_word_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rsbm_pkg::out_word_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [rsbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              loads_o,
  output int                              maps_o,
  output int                              inside_o,
  output int                              writes_o
);
  import rsbm_pkg::*;

  cfg_t       shadow;
  logic [7:0] texels [STORE_DIM*STORE_DIM];
  out_word_t  pending_pixels [$];
  int         n_in, n_out, fails;

  assign pending_o    = n_in - n_out;
  assign fail_count_o = fails;

  // Loads update the store and answer all-zero; maps go through the Q16
  // affine terms with 32-bit wrap, floor and the rectangle/store tests.
  function automatic out_word_t predict_pixel(in_word_t w);
    logic [31:0] sin32, cos32, cx, cy, bx, by, dy, sx, sy, col, row, scol, srow;
    out_word_t   r;
    r = '0;
    if (w.req_type == REQ_LOAD) begin
      if (w.load_col < STORE_DIM && w.load_row < STORE_DIM)
        texels[w.load_row * STORE_DIM + w.load_col] = w.load_value;
      return r;
    end
    sin32 = {{14{shadow.sin_q16[17]}}, shadow.sin_q16};
    cos32 = {{14{shadow.cos_q16[17]}}, shadow.cos_q16};
    cx    = 32'(shadow.half_box_width);
    cy    = 32'(shadow.half_box_height);
    bx    = 32'(w.box_x) % BOX_DIM;
    by    = 32'(w.box_y) % BOX_DIM;
    dy    = cy - by;
    sx = (cx << 16) - cos32 * cx + sin32 * dy
       + ((32'(shadow.rect_width) - (cx << 1)) << 15) + ROUND_BIAS + bx * cos32;
    sy = (cy << 16) - sin32 * cx - cos32 * dy
       + ((32'(shadow.rect_height) - (cy << 1)) << 15) + ROUND_BIAS + bx * sin32;
    // negative coordinates land at 32768 and up, so fail the width test
    col = sx >> 16;
    row = sy >> 16;
    if (col < 32'(shadow.rect_width) && row < 32'(shadow.rect_height)) begin
      scol = col + 32'(shadow.rect_left);
      srow = row + 32'(shadow.rect_top);
      if (scol < STORE_DIM && srow < STORE_DIM) begin
        r.inside_source = 1'b1;
        r.texel_out     = texels[srow * STORE_DIM + scol];
        r.write_dest    = (r.texel_out != 8'd0);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    int        bad;
    if (!rst_ni) begin
      shadow <= {18'd0, 18'h10000, 10'd0, 10'd0, 8'd0, 8'd0, 9'd0, 9'd0};
      pending_pixels.delete();
      n_in     <= 0;
      n_out    <= 0;
      fails    <= 0;
      loads_o  <= 0;
      maps_o   <= 0;
      inside_o <= 0;
      writes_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SIN_Q16:     shadow.sin_q16         <= cfg_data_i;
          CFG_COS_Q16:     shadow.cos_q16         <= cfg_data_i;
          CFG_HALF_BOX_W:  shadow.half_box_width  <= cfg_data_i[9:0];
          CFG_HALF_BOX_H:  shadow.half_box_height <= cfg_data_i[9:0];
          CFG_RECT_LEFT:   shadow.rect_left       <= cfg_data_i[7:0];
          CFG_RECT_TOP:    shadow.rect_top        <= cfg_data_i[7:0];
          CFG_RECT_WIDTH:  shadow.rect_width      <= cfg_data_i[8:0];
          CFG_RECT_HEIGHT: shadow.rect_height     <= cfg_data_i[8:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        n_out <= n_out + 1;
        bad = 0;
        if (pending_pixels.size() == 0) begin
          $error("result word with no expectation waiting: %h", out_data_i);
          bad = 1;
        end else begin
          want = pending_pixels.pop_front();
          if (out_data_i.write_dest !== want.write_dest) begin
            $error("write_dest: expected %0d, actual %0d",
                   want.write_dest, out_data_i.write_dest);
            bad++;
          end
          if (out_data_i.texel_out !== want.texel_out) begin
            $error("texel_out: expected %0d, actual %0d",
                   want.texel_out, out_data_i.texel_out);
            bad++;
          end
          if (out_data_i.inside_source !== want.inside_source) begin
            $error("inside_source: expected %0d, actual %0d",
                   want.inside_source, out_data_i.inside_source);
            bad++;
          end
        end
        fails <= fails + bad;
      end

      if (in_valid_i && !in_stall_i) begin
        n_in <= n_in + 1;
        want = predict_pixel(in_data_i);
        pending_pixels.push_back(want);
        if (in_data_i.req_type == REQ_LOAD) loads_o <= loads_o + 1;
        else                                maps_o  <= maps_o + 1;
        if (want.inside_source) inside_o <= inside_o + 1;
        if (want.write_dest)    writes_o <= writes_o + 1;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the rotated sprite blit mapper.
// Fills a corner of the texel store and the store's last texel, keeps every
// rectangle within what is filled, runs directed words over the rectangle
// edges, transparency, negative and off-store coordinates, then random
// rotations and extreme register settings with random idling on both sides.
// Scoring is left to blit_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tb;
  import rsbm_pkg::*;

  // five pipeline stages A..E between input and result
  localparam int PIPE_DEPTH   = 5;
  localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;
  // longest sender gap and receiver stall both come from gap_len; plenty of margin
  localparam int IDLE_LIMIT   = 1000;
  localparam int PHASE_WORDS  = 16;
  // side of the filled corner of the store
  localparam int FILL_DIM     = 16;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int fail_count, pending, n_loads, n_maps, n_inside, n_writes;
  int idle_cycles   = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int settings_seen = 0;

  rotated_sprite_blit_mapper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  blit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .loads_o      (n_loads),
    .maps_o       (n_maps),
    .inside_o     (n_inside),
    .writes_o     (n_writes)
  );

  initial forever #1 clk_i = ~clk_i;

  // Idle lengths drawn from three ranges, the shortest most often, now and then a long hole.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)      return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else             return $urandom_range(20, 60);
  endfunction

  // A quarter of the texels are transparent.
  function automatic logic [7:0] texel_value();
    if ($urandom_range(0, 3) == 0) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  // Box fields of a load word are junk; the block must ignore them.
  function automatic in_word_t load_word(int col, int row, logic [7:0] val);
    in_word_t w;
    w.req_type   = REQ_LOAD;
    w.load_col   = 8'(col);
    w.load_row   = 8'(row);
    w.load_value = val;
    w.box_x      = 11'($urandom);
    w.box_y      = 11'($urandom);
    return w;
  endfunction

  // Likewise the load fields of a map word.
  function automatic in_word_t map_word(int x, int y);
    in_word_t w;
    w.req_type   = REQ_MAP;
    w.load_col   = 8'($urandom);
    w.load_row   = 8'($urandom);
    w.load_value = 8'($urandom);
    w.box_x      = 11'(x);
    w.box_y      = 11'(y);
    return w;
  endfunction

  // Present one word, hold it until taken, then maybe leave a hole.
  // Valid stays up across back-to-back words.
  task automatic send_word(input in_word_t w);
    int n;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      n = gap_len();
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Every word yields one result, so an empty scoreboard means an idle block.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write all eight registers on consecutive edges. Unused upper data bits
  // of the narrow registers carry junk to show they are masked off.
  task automatic set_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    drain();
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_e'(i))
        CFG_SIN_Q16:     d = c.sin_q16;
        CFG_COS_Q16:     d = c.cos_q16;
        CFG_HALF_BOX_W:  d = {8'($urandom), c.half_box_width};
        CFG_HALF_BOX_H:  d = {8'($urandom), c.half_box_height};
        CFG_RECT_LEFT:   d = {10'($urandom), c.rect_left};
        CFG_RECT_TOP:    d = {10'($urandom), c.rect_top};
        CFG_RECT_WIDTH:  d = {9'($urandom), c.rect_width};
        default:         d = {9'($urandom), c.rect_height};
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= d;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // Receiver back-pressure: random stall bursts, off when the rate is zero.
  initial begin : stall_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 99) < out_stall_pct) stall_left = gap_len();
      end
    end
  end

  // Watchdog: a run of edges with no word moving anywhere means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    cfg_t c;
    real  ang, cr, sr, acr, asr;
    int   w, h, cx, cy, span_x, span_y, r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: empty rectangle, so maps never touch the store yet.
    send_word(map_word(0, 0));
    send_word(map_word(2047, 2047));

    // Fill the top-left corner; every rectangle below stays inside it or
    // reaches the store only at its last texel, written before any use.
    in_gap_pct    = 5;
    out_stall_pct = 5;
    for (int row = 0; row < FILL_DIM; row++)
      for (int col = 0; col < FILL_DIM; col++)
        send_word(load_word(col, row, texel_value()));

    // Identity mapping, 16x16 rectangle at the origin: column = x, row = y.
    in_gap_pct    = 20;
    out_stall_pct = 20;
    c = '0;
    c.cos_q16 = 18'h10000;
    c.half_box_width  = 10'd8;
    c.half_box_height = 10'd8;
    c.rect_width  = 9'd16;
    c.rect_height = 9'd16;
    set_config(c);
    send_word(load_word(0, 0, 8'd0));
    send_word(map_word(0, 0));          // transparent texel: inside, no write
    send_word(load_word(0, 0, 8'd255));
    send_word(map_word(0, 0));          // opaque: write of 255
    send_word(map_word(15, 15));        // far corner of the rectangle
    send_word(map_word(16, 0));         // one past the right edge
    send_word(map_word(0, 16));         // one past the bottom edge
    send_word(map_word(2047, 2047));    // box coordinates at their top
    send_word(load_word(255, 255, 8'd255));
    send_word(load_word(255, 0, 8'd1));
    send_word(map_word(7, 3));

    // Rectangle pinned to the store's last texel and hanging off the store:
    // column = x - 72, so small x goes negative and x = 73 leaves the store.
    c.half_box_width  = 10'd200;
    c.half_box_height = 10'd200;
    c.rect_left   = 8'd255;
    c.rect_top    = 8'd255;
    c.rect_width  = 9'd256;
    c.rect_height = 9'd256;
    set_config(c);
    send_word(map_word(0, 0));
    send_word(map_word(71, 72));
    send_word(map_word(72, 72));
    send_word(map_word(73, 72));
    send_word(map_word(72, 73));
    send_word(map_word(2047, 0));

    // Random part: a few extreme settings, then random rotations.
    for (int ph = 0; ph < 8; ph++) begin
      c = '0;
      case (ph)
        0: begin
          // quarter turn over a small rectangle
          c.sin_q16 = 18'h10000;
          c.half_box_width  = 10'd9;
          c.half_box_height = 10'd9;
          c.rect_width  = 9'd16;
          c.rect_height = 9'd16;
        end
        1: begin
          // both terms at minus one in Q16, largest box, corner rectangle
          c.sin_q16 = -18'sd65536;
          c.cos_q16 = -18'sd65536;
          c.half_box_width  = 10'd1023;
          c.half_box_height = 10'd1023;
          c.rect_width  = 9'(FILL_DIM);
          c.rect_height = 9'(FILL_DIM);
        end
        2: begin
          // half turn, empty rectangle in the far corner
          c.cos_q16 = -18'sd65536;
          c.rect_left = 8'd255;
          c.rect_top  = 8'd255;
        end
        3: begin
          // rotation, box and rectangle sizes at random, terms beyond a unit
          // rotation; the rectangle hangs off the store's last texel
          c.sin_q16 = 18'($urandom);
          c.cos_q16 = 18'($urandom);
          c.half_box_width  = 10'($urandom);
          c.half_box_height = 10'($urandom);
          c.rect_left   = 8'd255;
          c.rect_top    = 8'd255;
          c.rect_width  = 9'($urandom);
          c.rect_height = 9'($urandom);
        end
        default: begin
          // a real rotation with the box sized round the rotated rectangle
          ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
          cr  = $cos(ang);
          sr  = $sin(ang);
          acr = (cr < 0.0) ? -cr : cr;
          asr = (sr < 0.0) ? -sr : sr;
          w = $urandom_range(1, FILL_DIM);
          h = $urandom_range(1, FILL_DIM);
          cx = $rtoi(w * acr + h * asr) / 2 + 1;
          cy = $rtoi(w * asr + h * acr) / 2 + 1;
          c.cos_q16 = 18'($rtoi(cr * 65536.0));
          c.sin_q16 = 18'($rtoi(-sr * 65536.0));
          c.half_box_width  = 10'((cx > 1023) ? 1023 : cx);
          c.half_box_height = 10'((cy > 1023) ? 1023 : cy);
          c.rect_width  = 9'(w);
          c.rect_height = 9'(h);
          // now and then let the rectangle run off the store
          if ($urandom_range(0, 4) == 0) begin
            c.rect_left = 8'd255;
            c.rect_top  = 8'd255;
          end else begin
            c.rect_left = 8'($urandom_range(0, FILL_DIM - w));
            c.rect_top  = 8'($urandom_range(0, FILL_DIM - h));
          end
        end
      endcase
      set_config(c);

      span_x = 2 * c.half_box_width + 1;
      span_y = 2 * c.half_box_height + 1;
      if (span_x > 2047) span_x = 2047;
      if (span_y > 2047) span_y = 2047;

      for (int k = 0; k < PHASE_WORDS; k++) begin
        // a calm stretch at the head of each half phase, no idling either side
        if ((k % 8) < 2) begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end else begin
          in_gap_pct    = 30;
          out_stall_pct = 25;
        end
        r = $urandom_range(0, 99);
        if (r < 12)
          send_word(load_word($urandom_range(0, 255), $urandom_range(0, 255), texel_value()));
        else if (r < 22)
          send_word(map_word($urandom_range(0, 2047), $urandom_range(0, 2047)));
        else
          send_word(map_word($urandom_range(0, span_x), $urandom_range(0, span_y)));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d load and %0d map words across %0d register settings.",
             n_loads, n_maps, settings_seen);
    $display("%0d maps landed in the source rectangle, %0d of them drew a texel.",
             n_inside, n_writes);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rsbm_pkg.sv
rtl/rsbm_map_arith.sv
rtl/rsbm_texel_store.sv
rtl/rotated_sprite_blit_mapper.sv
rtl/rsbm_checker.sv
tb/blit_checker.sv
tb/tb.sv
